### rtl/weighted_label_vote_unit_macros.svh
// assertion macros for the weighted label vote unit
// used by weighted_label_vote_unit.sv, expects clk and rst_n in scope
`ifndef WEIGHTED_LABEL_VOTE_UNIT_MACROS_SVH
`define WEIGHTED_LABEL_VOTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WLV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wlv check failed: same cycle implication");
// next-cycle implication
`define WLV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wlv check failed: next cycle implication");
`else
`define WLV_ASSERT_NOW(label, ante, cons)
`define WLV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/wlv_pkg.sv
// shared types and constants for the weighted label vote unit
// no dependencies
`default_nettype none

package wlv_pkg;

    localparam int CLASS_COUNT_DEF = 4;
    localparam int LEVEL_COUNT_DEF = 4;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int LABEL_BITS     = 3;
    localparam int LEVEL_SEL_BITS = 2;
    localparam int LABEL_INPUTS   = 4;
    localparam int MAX_LABEL      = 7;
    localparam int LOAD_BITS      = 16;
    localparam int SCORE_BITS     = 17;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_VOTE = 1'b1;

    typedef struct packed {
        logic [LABEL_BITS-1:0] winner;
        logic [SCORE_BITS-1:0] score;
    } wlv_result_t;

endpackage

`default_nettype wire

### rtl/wlv_decide.sv
// picks the winning class and the saturated best score from the class sums
// depends on wlv_pkg
`default_nettype none

module wlv_decide #(
    parameter int CLS_USED = 4,
    parameter int SUM_BITS = 19
) (
    input  logic signed [SUM_BITS-1:0] sums [CLS_USED],
    output wlv_pkg::wlv_result_t       result
);
    import wlv_pkg::*;

    logic [CLS_USED-1:0]   is_max;
    logic                  single;
    logic [LABEL_BITS-1:0] winner_sel;
    logic [SUM_BITS-1:0]   best_sel;
    logic [SCORE_BITS-1:0] best_sat;

    // a class is a candidate when its sum is positive and no other sum beats it
    always_comb
    begin
        logic top;
        is_max = '0;
        for (int c = 0; c < CLS_USED; c++)
        begin
            top = !sums[c][SUM_BITS-1] && (sums[c] != '0);
            for (int d = 0; d < CLS_USED; d++)
            begin
                if (sums[d] > sums[c])
                begin
                    top = 1'b0;
                end
            end
            is_max[c] = top;
        end
    end

    // all candidates share the same sum, so or-ing them is safe
    always_comb
    begin
        winner_sel = '0;
        best_sel   = '0;
        for (int c = 0; c < CLS_USED; c++)
        begin
            if (is_max[c])
            begin
                winner_sel = winner_sel | LABEL_BITS'(c + 1);
                best_sel   = best_sel | SUM_BITS'(sums[c]);
            end
        end
    end

    // two or more equal maxima make a tie
    assign single = (is_max != '0) && ((is_max & (is_max - CLS_USED'(1))) == '0);

    generate
        if (SUM_BITS > SCORE_BITS)
        begin : g_sat
            assign best_sat = (best_sel[SUM_BITS-1:SCORE_BITS] != '0) ?
                              {SCORE_BITS{1'b1}} : best_sel[SCORE_BITS-1:0];
        end
        else
        begin : g_nosat
            assign best_sat = SCORE_BITS'(best_sel);
        end
    endgenerate

    assign result.winner = single ? winner_sel : '0;
    assign result.score  = best_sat;

endmodule

`default_nettype wire

### rtl/weighted_label_vote_unit.sv
// top level of the weighted label vote unit: weight table, class sums, result stage
// depends on wlv_pkg, wlv_decide and weighted_label_vote_unit_macros.svh
`default_nettype none
`include "weighted_label_vote_unit_macros.svh"

// Weighted label vote unit. A load request (operation 0) writes one signed
// Q2.14 weight for a class and a level into a table held in flip-flops that
// reset clears to zero; it gives no result, and a load to an unknown class or
// level is dropped. A vote request (operation 1) carries one label per level
// and gives one result: the class whose summed weights are strictly largest
// and positive, or class 0 when no sum is positive or the largest is shared,
// together with the best score saturated to 17 bits. The unit takes one
// request every cycle while in_stall is low. A vote that is taken passes the
// input register, the class sum register and the result register in order.
// Each stage moves on whenever it is empty or the stage after it moves, so
// the input stalls only when all three stages hold a vote and the output is
// stalled. A load written in a cycle is seen by every vote taken after it.
module weighted_label_vote_unit #(
    parameter int CLASS_COUNT = wlv_pkg::CLASS_COUNT_DEF,
    parameter int LEVEL_COUNT = wlv_pkg::LEVEL_COUNT_DEF,
    parameter int WEIGHT_BITS = wlv_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [wlv_pkg::LABEL_BITS-1:0]      weight_class,
    input  logic [wlv_pkg::LEVEL_SEL_BITS-1:0]  weight_level,
    input  logic signed [wlv_pkg::LOAD_BITS-1:0] weight_value,
    input  logic [wlv_pkg::LABEL_BITS-1:0]      level0_label,
    input  logic [wlv_pkg::LABEL_BITS-1:0]      level1_label,
    input  logic [wlv_pkg::LABEL_BITS-1:0]      level2_label,
    input  logic [wlv_pkg::LABEL_BITS-1:0]      level3_label,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [wlv_pkg::LABEL_BITS-1:0]      winning_class,
    output logic [wlv_pkg::SCORE_BITS-1:0]      best_score
);
    import wlv_pkg::*;

    localparam int ACT_LEVELS = (LEVEL_COUNT < LABEL_INPUTS) ? LEVEL_COUNT : LABEL_INPUTS;
    localparam int CLS_USED   = (CLASS_COUNT < MAX_LABEL) ? CLASS_COUNT : MAX_LABEL;
    localparam int SUM_BITS   = WEIGHT_BITS + $clog2(ACT_LEVELS + 1);

    logic [LABEL_BITS-1:0]         in_labels [LABEL_INPUTS];
    logic                          in_accept;
    logic                          load_hit;
    logic signed [WEIGHT_BITS-1:0] fit_weight;

    logic signed [WEIGHT_BITS-1:0] weight_table_reg [ACT_LEVELS][CLS_USED];

    logic                  s1_valid_reg;
    logic [LABEL_BITS-1:0] label_reg [ACT_LEVELS];
    logic                  s2_valid_reg;
    logic signed [SUM_BITS-1:0] sums_reg  [CLS_USED];
    logic signed [SUM_BITS-1:0] sums_next [CLS_USED];
    logic                  out_valid_reg;
    wlv_result_t           result_reg;
    wlv_result_t           result_next;

    logic out_adv;
    logic s2_adv;
    logic s1_adv;

    assign in_labels[0] = level0_label;
    assign in_labels[1] = level1_label;
    assign in_labels[2] = level2_label;
    assign in_labels[3] = level3_label;

    // pipeline advance, stalls ripple back from the output
    assign out_adv   = !out_valid_reg || !out_stall;
    assign s2_adv    = !s2_valid_reg || out_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign in_stall  = !s1_adv;
    assign in_accept = in_valid && !in_stall;

    assign load_hit = in_accept && (operation == OP_LOAD) && (weight_class != '0) &&
                      (32'(weight_class) <= CLASS_COUNT) && (32'(weight_level) < LEVEL_COUNT);

    // fit the loaded value into the table width
    generate
        if (WEIGHT_BITS >= LOAD_BITS)
        begin : g_wide
            assign fit_weight = WEIGHT_BITS'(weight_value);
        end
        else
        begin : g_narrow
            localparam logic signed [LOAD_BITS-1:0] W_HI = LOAD_BITS'((1 << (WEIGHT_BITS - 1)) - 1);
            localparam logic signed [LOAD_BITS-1:0] W_LO = -W_HI - LOAD_BITS'(1);
            assign fit_weight = (weight_value > W_HI) ? W_HI[WEIGHT_BITS-1:0] :
                                (weight_value < W_LO) ? W_LO[WEIGHT_BITS-1:0] :
                                weight_value[WEIGHT_BITS-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < ACT_LEVELS; l++)
            begin
                for (int c = 0; c < CLS_USED; c++)
                begin
                    weight_table_reg[l][c] <= '0;
                end
            end
        end
        else if (load_hit)
        begin
            for (int l = 0; l < ACT_LEVELS; l++)
            begin
                for (int c = 0; c < CLS_USED; c++)
                begin
                    if ((weight_level == LEVEL_SEL_BITS'(l)) &&
                        (weight_class == LABEL_BITS'(c + 1)))
                    begin
                        weight_table_reg[l][c] <= fit_weight;
                    end
                end
            end
        end
    end

    // per class sum of the weights of the levels that voted for it
    always_comb
    begin
        logic signed [SUM_BITS-1:0] acc;
        for (int c = 0; c < CLS_USED; c++)
        begin
            acc = '0;
            for (int l = 0; l < ACT_LEVELS; l++)
            begin
                if (label_reg[l] == LABEL_BITS'(c + 1))
                begin
                    acc = acc + SUM_BITS'(weight_table_reg[l][c]);
                end
            end
            sums_next[c] = acc;
        end
    end

    wlv_decide #(
        .CLS_USED (CLS_USED),
        .SUM_BITS (SUM_BITS)
    ) u_decide (
        .sums   (sums_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_accept && (operation == OP_VOTE);
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_accept)
        begin
            for (int l = 0; l < ACT_LEVELS; l++)
            begin
                label_reg[l] <= in_labels[l];
            end
        end
        if (s2_adv && s1_valid_reg)
        begin
            for (int c = 0; c < CLS_USED; c++)
            begin
                sums_reg[c] <= sums_next[c];
            end
        end
        if (out_adv && s2_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign winning_class = result_reg.winner;
    assign best_score    = result_reg.score;

    // a named winner always carries a positive score
    `WLV_ASSERT_NOW(a_winner_has_score, out_valid && (winning_class != '0), best_score != '0)
    // an accepted vote always lands in the input stage
    `WLV_ASSERT_NEXT(a_vote_captured, in_accept && (operation == OP_VOTE), s1_valid_reg)
    // the input side stalls only when every stage holds a vote
    `WLV_ASSERT_NOW(a_stall_only_full, in_stall, s1_valid_reg && s2_valid_reg && out_valid_reg)

endmodule

`default_nettype wire

### bench/tb_top.sv
// self-checking bench for weighted_label_vote_unit: random and directed load/vote requests
// depends on wlv_pkg and the unit rtl; predicts each vote from a local copy of the weight table
`timescale 1ns / 1ps

module tb_top;
    import wlv_pkg::*;

    localparam int CLASS_COUNT = CLASS_COUNT_DEF;
    localparam int LEVEL_COUNT = LEVEL_COUNT_DEF;
    localparam int WEIGHT_BITS = WEIGHT_BITS_DEF;
    localparam int SCORE_CAP   = (1 << SCORE_BITS) - 1;

    localparam int RANDOM_REQUESTS = 2000;
    localparam int PHASE_ONE_END   = 700;
    localparam int PHASE_TWO_END   = 1400;
    localparam int HOLD_AT         = 1550;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic                                    op;
        logic [LABEL_BITS-1:0]                   cls;
        logic [LEVEL_SEL_BITS-1:0]               lev;
        logic signed [LOAD_BITS-1:0]             val;
        logic [LABEL_INPUTS-1:0][LABEL_BITS-1:0] labels;
    } vote_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        operation = OP_LOAD;
    logic [LABEL_BITS-1:0]       weight_class = '0;
    logic [LEVEL_SEL_BITS-1:0]   weight_level = '0;
    logic signed [LOAD_BITS-1:0] weight_value = '0;
    logic [LABEL_BITS-1:0]       level0_label = '0;
    logic [LABEL_BITS-1:0]       level1_label = '0;
    logic [LABEL_BITS-1:0]       level2_label = '0;
    logic [LABEL_BITS-1:0]       level3_label = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [LABEL_BITS-1:0]       winning_class;
    logic [SCORE_BITS-1:0]       best_score;

    vote_req_t            pending_requests[$];
    wlv_result_t          expected_votes[$];
    logic signed [WEIGHT_BITS-1:0] shadow_weights [CLASS_COUNT][LEVEL_COUNT];

    bit in_took = 1'b0;
    int taken_count = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    weighted_label_vote_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .weight_class (weight_class),
        .weight_level (weight_level),
        .weight_value (weight_value),
        .level0_label (level0_label),
        .level1_label (level1_label),
        .level2_label (level2_label),
        .level3_label (level3_label),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .winning_class(winning_class),
        .best_score   (best_score)
    );

    always #1 clk = ~clk;

    // applies a load to the shadow table, or scores a vote; returns 1 when a result is due
    function automatic bit fuse_labels(input vote_req_t r, output wlv_result_t res);
        int sums [CLASS_COUNT+1];
        int best;
        int winner;
        int lab;
        res = '0;
        if (r.op == OP_LOAD)
        begin
            if (r.cls >= 1 && r.cls <= CLASS_COUNT && r.lev < LEVEL_COUNT)
            begin
                shadow_weights[r.cls-1][r.lev] = WEIGHT_BITS'(r.val);
            end
            return 1'b0;
        end
        for (int c = 0; c <= CLASS_COUNT; c++)
        begin
            sums[c] = 0;
        end
        for (int l = 0; l < LEVEL_COUNT && l < LABEL_INPUTS; l++)
        begin
            lab = int'(r.labels[l]);
            if (lab >= 1 && lab <= CLASS_COUNT)
            begin
                sums[lab] += int'(shadow_weights[lab-1][l]);
            end
        end
        best = 0;
        winner = 0;
        for (int c = 1; c <= CLASS_COUNT; c++)
        begin
            if (sums[c] > best)
            begin
                best = sums[c];
                winner = c;
            end
            else if (sums[c] == best)
            begin
                winner = 0;
            end
        end
        if (best > SCORE_CAP)
        begin
            best = SCORE_CAP;
        end
        res.winner = winner[LABEL_BITS-1:0];
        res.score = best[SCORE_BITS-1:0];
        return 1'b1;
    endfunction

    // every field random, so the unused half of each request toggles too
    function automatic vote_req_t noise_request();
        vote_req_t r;
        r.op = 1'($urandom_range(0, 1));
        r.cls = LABEL_BITS'($urandom_range(0, 7));
        r.lev = LEVEL_SEL_BITS'($urandom_range(0, 3));
        r.val = LOAD_BITS'($urandom());
        for (int l = 0; l < LABEL_INPUTS; l++)
        begin
            r.labels[l] = LABEL_BITS'($urandom_range(0, MAX_LABEL));
        end
        return r;
    endfunction

    function automatic vote_req_t load_req(input int cls, input int lev, input int val);
        vote_req_t r;
        r = noise_request();
        r.op = OP_LOAD;
        r.cls = LABEL_BITS'(cls);
        r.lev = LEVEL_SEL_BITS'(lev);
        r.val = LOAD_BITS'(val);
        return r;
    endfunction

    function automatic vote_req_t vote_req(input int l0, input int l1, input int l2, input int l3);
        vote_req_t r;
        r = noise_request();
        r.op = OP_VOTE;
        r.labels[0] = LABEL_BITS'(l0);
        r.labels[1] = LABEL_BITS'(l1);
        r.labels[2] = LABEL_BITS'(l2);
        r.labels[3] = LABEL_BITS'(l3);
        return r;
    endfunction

    // mostly coarse or extreme weights so that equal sums show up often
    function automatic logic signed [LOAD_BITS-1:0] pick_weight();
        logic signed [LOAD_BITS-1:0] w;
        case ($urandom_range(0, 3))
            0: w = LOAD_BITS'($urandom());
            1: w = LOAD_BITS'($signed($urandom_range(0, 8)) * 4096 - 16384);
            2: w = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: w = LOAD_BITS'($urandom_range(0, 3) * 8192);
        endcase
        return w;
    endfunction

    function automatic vote_req_t random_request();
        vote_req_t r;
        r = noise_request();
        if ($urandom_range(0, 99) < 12)
        begin
            r.op = OP_LOAD;
            r.cls = LABEL_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                             : $urandom_range(1, 4));
            r.val = pick_weight();
        end
        else
        begin
            r.op = OP_VOTE;
            for (int l = 0; l < LABEL_INPUTS; l++)
            begin
                r.labels[l] = LABEL_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                                       : $urandom_range(0, 4));
            end
        end
        return r;
    endfunction

    function automatic int idle_pct(input bit sender);
        if (taken_count < PHASE_ONE_END)
            return sender ? 32 : 87;
        else if (taken_count < PHASE_TWO_END)
            return sender ? 87 : 32;
        else
            return 0;
    endfunction

    // sender: a request stays on the bus until taken
    always @(negedge clk)
    begin
        vote_req_t cur;
        if (rst_n && (!in_valid || in_took))
        begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1))
            begin
                cur = pending_requests.pop_front();
                operation    <= cur.op;
                weight_class <= cur.cls;
                weight_level <= cur.lev;
                weight_value <= cur.val;
                level0_label <= cur.labels[0];
                level1_label <= cur.labels[1];
                level2_label <= cur.labels[2];
                level3_label <= cur.labels[3];
                in_valid     <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off while the sender keeps pushing
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && taken_count >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
        end
    end

    // monitor: predict on every taken request, check every taken result
    always @(posedge clk)
    begin
        vote_req_t req;
        wlv_result_t want;
        in_took = 1'b0;
        if (rst_n)
        begin
            in_took = in_valid && !in_stall;
            if (in_took)
            begin
                req.op = operation;
                req.cls = weight_class;
                req.lev = weight_level;
                req.val = weight_value;
                req.labels[0] = level0_label;
                req.labels[1] = level1_label;
                req.labels[2] = level2_label;
                req.labels[3] = level3_label;
                if (fuse_labels(req, want))
                begin
                    expected_votes.push_back(want);
                end
                taken_count++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_votes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got class %0d score %0d",
                             $time, winning_class, best_score);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_votes.pop_front();
                    if (winning_class !== want.winner)
                    begin
                        $display("%0t: winning_class expected %0d, got %0d",
                                 $time, want.winner, winning_class);
                        mismatch_count++;
                    end
                    if (best_score !== want.score)
                    begin
                        $display("%0t: best_score expected %0d, got %0d",
                                 $time, want.score, best_score);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            for (int l = 0; l < LEVEL_COUNT; l++)
            begin
                shadow_weights[c][l] = '0;
            end
        end

        // cleared table: empty vote and a four-way tie at zero
        pending_requests.push_back(vote_req(0, 0, 0, 0));
        pending_requests.push_back(vote_req(1, 2, 3, 4));
        // largest possible score
        for (int l = 0; l < LEVEL_COUNT; l++)
        begin
            pending_requests.push_back(load_req(1, l, 32767));
        end
        pending_requests.push_back(vote_req(1, 1, 1, 1));
        // most negative weight never wins
        pending_requests.push_back(load_req(2, 0, -32768));
        pending_requests.push_back(vote_req(2, 0, 0, 0));
        // loads to unknown classes are dropped
        pending_requests.push_back(load_req(0, 1, 16384));
        pending_requests.push_back(load_req(5, 2, 16384));
        pending_requests.push_back(load_req(7, 3, -1));
        // unknown labels add nothing
        pending_requests.push_back(vote_req(7, 6, 5, 0));
        // tie between two positive sums keeps the score, clears the class
        pending_requests.push_back(load_req(3, 1, 16384));
        pending_requests.push_back(load_req(4, 2, 16384));
        pending_requests.push_back(vote_req(0, 3, 4, 0));
        pending_requests.push_back(load_req(4, 3, 1));
        pending_requests.push_back(vote_req(0, 3, 4, 4));
        pending_requests.push_back(vote_req(1, 3, 4, 4));
        // negative sum against zero sums
        pending_requests.push_back(load_req(2, 1, 12345));
        pending_requests.push_back(vote_req(2, 2, 0, 0));
        pending_requests.push_back(vote_req(0, 0, 3, 0));
        pending_requests.push_back(load_req(3, 2, 20000));
        pending_requests.push_back(vote_req(4, 3, 3, 1));

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            pending_requests.push_back(random_request());
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_votes.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
